// ===== hw/rtl/mpbu_pkg.sv =====
`timescale 1ns / 1ps

package mpbu_pkg;

    localparam int WORD_BITS    = 32;
    localparam int BUF_BITS     = 128;
    localparam int HELD_W       = 7;
    localparam int WID_W        = 6;
    localparam int CNT_W        = 6;
    localparam int MAX_PER_ITEM = 32;
    localparam int MID_DEPTH    = 2;
    localparam int OUT_DEPTH    = 4;

    typedef enum logic [2:0] {
        CFG_SPAN_X = 3'd0,
        CFG_SPAN_Y = 3'd1,
        CFG_SPAN_Z = 3'd2,
        CFG_BASE_X = 3'd3,
        CFG_BASE_Y = 3'd4,
        CFG_BASE_Z = 3'd5,
        CFG_VTOTAL = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        KIND_STREAM = 1'b0,
        KIND_SINGLE = 1'b1
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        t_kind                kind;
    } t_mid_item;

    typedef struct packed {
        logic [WID_W-1:0]     wid_x;
        logic [HELD_W-1:0]    off_z;
        logic [HELD_W-1:0]    total;
        logic [WORD_BITS-1:0] mask_x;
        logic [WORD_BITS-1:0] mask_y;
        logic [WORD_BITS-1:0] mask_z;
        logic [WORD_BITS-1:0] base_x;
        logic [WORD_BITS-1:0] base_y;
        logic [WORD_BITS-1:0] base_z;
        logic [7:0]           vtotal;
    } t_cfg;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] pos_x;
        logic signed [WORD_BITS-1:0] pos_y;
        logic signed [WORD_BITS-1:0] pos_z;
        logic [7:0]                  vertex_number;
        logic                        final_vertex;
    } t_result;

    function automatic logic [WID_W-1:0] bit_len(input logic [WORD_BITS-1:0] v);
        logic [WID_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) begin
                n = WID_W'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [WORD_BITS-1:0] low_mask(input logic [WID_W-1:0] w);
        logic [WORD_BITS:0] m;
        m = ({{WORD_BITS{1'b0}}, 1'b1} << w) - {{WORD_BITS{1'b0}}, 1'b1};
        return m[WORD_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/mpbu_queue.sv =====
`timescale 1ns / 1ps

module mpbu_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [WIDTH-1:0]                 i_data,
    output logic                             o_full,
    input  logic                             i_pop,
    output logic                             o_empty,
    output logic [WIDTH-1:0]                 o_data,
    output logic [$clog2(DEPTH+1)-1:0]       o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/mpbu_front.sv =====
`timescale 1ns / 1ps

module mpbu_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [2:0]                         i_cfg_index,
    input  logic [mpbu_pkg::WORD_BITS-1:0]     i_cfg_data,
    input  logic                               i_push,
    input  logic [mpbu_pkg::WORD_BITS-1:0]     i_word,
    input  logic                               i_mid_full,
    output logic                               o_mid_push,
    output mpbu_pkg::t_mid_item                o_mid_item,
    output mpbu_pkg::t_cfg                     o_cfg
);
    logic [mpbu_pkg::WID_W-1:0]     r_wid_x;
    logic [mpbu_pkg::WID_W-1:0]     r_wid_y;
    logic [mpbu_pkg::WID_W-1:0]     r_wid_z;
    logic [mpbu_pkg::WORD_BITS-1:0] r_mask_x;
    logic [mpbu_pkg::WORD_BITS-1:0] r_mask_y;
    logic [mpbu_pkg::WORD_BITS-1:0] r_mask_z;
    logic [mpbu_pkg::WORD_BITS-1:0] r_base_x;
    logic [mpbu_pkg::WORD_BITS-1:0] r_base_y;
    logic [mpbu_pkg::WORD_BITS-1:0] r_base_z;
    logic [7:0]                     r_vtotal;
    logic [mpbu_pkg::WID_W-1:0]     in_wid;
    logic [mpbu_pkg::HELD_W-1:0]    off_z;
    logic [mpbu_pkg::HELD_W-1:0]    total;

    assign o_cfg_ready = 1'b1;
    assign in_wid      = mpbu_pkg::bit_len(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wid_x  <= '0;
            r_wid_y  <= '0;
            r_wid_z  <= '0;
            r_mask_x <= '0;
            r_mask_y <= '0;
            r_mask_z <= '0;
            r_base_x <= '0;
            r_base_y <= '0;
            r_base_z <= '0;
            r_vtotal <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mpbu_pkg::CFG_SPAN_X: begin
                    r_wid_x  <= in_wid;
                    r_mask_x <= mpbu_pkg::low_mask(in_wid);
                end
                mpbu_pkg::CFG_SPAN_Y: begin
                    r_wid_y  <= in_wid;
                    r_mask_y <= mpbu_pkg::low_mask(in_wid);
                end
                mpbu_pkg::CFG_SPAN_Z: begin
                    r_wid_z  <= in_wid;
                    r_mask_z <= mpbu_pkg::low_mask(in_wid);
                end
                mpbu_pkg::CFG_BASE_X: r_base_x <= i_cfg_data;
                mpbu_pkg::CFG_BASE_Y: r_base_y <= i_cfg_data;
                mpbu_pkg::CFG_BASE_Z: r_base_z <= i_cfg_data;
                mpbu_pkg::CFG_VTOTAL: r_vtotal <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign off_z = {1'b0, r_wid_x} + {1'b0, r_wid_y};
    assign total = off_z + {1'b0, r_wid_z};

    always_comb begin
        o_cfg.wid_x  = r_wid_x;
        o_cfg.off_z  = off_z;
        o_cfg.total  = total;
        o_cfg.mask_x = r_mask_x;
        o_cfg.mask_y = r_mask_y;
        o_cfg.mask_z = r_mask_z;
        o_cfg.base_x = r_base_x;
        o_cfg.base_y = r_base_y;
        o_cfg.base_z = r_base_z;
        o_cfg.vtotal = r_vtotal;
    end

    // with no vertices configured a word has no effect at all, so it dies here
    assign o_mid_push      = i_push && !i_mid_full && (r_vtotal != '0);
    assign o_mid_item.word = i_word;
    assign o_mid_item.kind = (total == '0) ? mpbu_pkg::KIND_SINGLE : mpbu_pkg::KIND_STREAM;

endmodule

// ===== hw/rtl/mpbu_back.sv =====
`timescale 1ns / 1ps

module mpbu_back #(
    parameter int OUT_DEPTH = mpbu_pkg::OUT_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mpbu_pkg::t_cfg                     i_cfg,
    input  logic                               i_mid_empty,
    input  mpbu_pkg::t_mid_item                i_mid_item,
    output logic                               o_mid_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]     i_out_count,
    output logic                               o_out_push,
    output mpbu_pkg::t_result                  o_out_data
);
    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam int BB = mpbu_pkg::BUF_BITS;
    localparam int WB = mpbu_pkg::WORD_BITS;
    localparam int HW = mpbu_pkg::HELD_W;

    mpbu_pkg::t_back_state r_state, n_state;
    mpbu_pkg::t_kind       r_kind, n_kind;

    logic [BB-1:0]               r_buf, n_buf;
    logic [HW-1:0]               r_held, n_held;
    logic [7:0]                  r_done, n_done;
    logic [mpbu_pkg::CNT_W-1:0]  r_count, n_count;

    logic                        r_s1_valid;
    logic [WB-1:0]               r_s1_x;
    logic [WB-1:0]               r_s1_y;
    logic [WB-1:0]               r_s1_z;
    logic [7:0]                  r_s1_num;
    logic                        r_s1_last;

    logic                        start;
    logic                        issue;
    logic                        more;
    logic                        credit;
    logic                        last;
    logic                        restart;
    logic [BB-1:0]               base_buf;
    logic [HW-1:0]               base_held;
    logic [BB-1:0]               word_sh;
    logic [3*WB-1:0]             y_sh;
    logic [3*WB-1:0]             z_sh;
    logic [8:0]                  done_inc;

    assign done_inc = {1'b0, r_done} + 9'd1;
    assign last     = (done_inc == {1'b0, i_cfg.vtotal});
    assign credit   = ({1'b0, i_out_count} + (CW + 1)'(r_s1_valid)) < (CW + 1)'(OUT_DEPTH);
    assign more     = (r_count < mpbu_pkg::CNT_W'(mpbu_pkg::MAX_PER_ITEM))
                   && (r_done < i_cfg.vtotal)
                   && ((r_kind == mpbu_pkg::KIND_SINGLE) ? (r_count == '0)
                                                         : (r_held >= i_cfg.total));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mpbu_pkg::ST_IDLE: begin
                if (!i_mid_empty) begin
                    n_state = mpbu_pkg::ST_RUN;
                end
            end
            mpbu_pkg::ST_RUN: begin
                if (!more || (credit && last)) begin
                    n_state = mpbu_pkg::ST_IDLE;
                end
            end
            default: n_state = mpbu_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        start = 1'b0;
        issue = 1'b0;
        case (r_state)
            mpbu_pkg::ST_IDLE: start = !i_mid_empty;
            mpbu_pkg::ST_RUN:  issue = more && credit;
            default: ;
        endcase
    end

    assign o_mid_pop = start;

    // a meshlet that already ended restarts with the next word
    assign restart   = (r_done >= i_cfg.vtotal);
    assign base_buf  = restart ? '0 : r_buf;
    assign base_held = restart ? '0 : r_held;
    assign word_sh   = {{(BB - WB){1'b0}}, i_mid_item.word} << base_held;
    assign y_sh      = r_buf[3*WB-1:0] >> i_cfg.wid_x;
    assign z_sh      = r_buf[3*WB-1:0] >> i_cfg.off_z;

    always_comb begin
        n_buf   = r_buf;
        n_held  = r_held;
        n_done  = r_done;
        n_count = r_count;
        n_kind  = r_kind;
        if (start) begin
            n_kind  = i_mid_item.kind;
            n_count = '0;
            n_done  = restart ? '0 : r_done;
            if (i_mid_item.kind == mpbu_pkg::KIND_STREAM) begin
                n_buf  = base_buf | word_sh;
                n_held = base_held + HW'(WB);
            end else begin
                n_buf  = base_buf;
                n_held = base_held;
            end
        end else if (issue) begin
            n_count = r_count + 1'b1;
            if (last) begin
                n_buf  = '0;
                n_held = '0;
                n_done = '0;
            end else begin
                n_buf  = r_buf >> i_cfg.total;
                n_held = r_held - i_cfg.total;
                n_done = done_inc[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mpbu_pkg::ST_IDLE;
            r_kind     <= mpbu_pkg::KIND_STREAM;
            r_buf      <= '0;
            r_held     <= '0;
            r_done     <= '0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_kind     <= n_kind;
            r_buf      <= n_buf;
            r_held     <= n_held;
            r_done     <= n_done;
            r_count    <= n_count;
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_x    <= r_buf[WB-1:0] & i_cfg.mask_x;
            r_s1_y    <= y_sh[WB-1:0] & i_cfg.mask_y;
            r_s1_z    <= z_sh[WB-1:0] & i_cfg.mask_z;
            r_s1_num  <= r_done;
            r_s1_last <= last;
        end
    end

    assign o_out_push                 = r_s1_valid;
    assign o_out_data.pos_x           = r_s1_x + i_cfg.base_x;
    assign o_out_data.pos_y           = r_s1_y + i_cfg.base_y;
    assign o_out_data.pos_z           = r_s1_z + i_cfg.base_z;
    assign o_out_data.vertex_number   = r_s1_num;
    assign o_out_data.final_vertex    = r_s1_last;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (i_out_count < CW'(OUT_DEPTH)))
        else $error("vertex written into a full result queue");

    a_pop_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mid_pop |=> (r_state == mpbu_pkg::ST_RUN && r_count == '0))
        else $error("word taken without starting a run");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mpbu_pkg::CNT_W'(mpbu_pkg::MAX_PER_ITEM))
        else $error("too many vertices for one word");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && last) |=> (r_done == '0 && r_held == '0 && r_s1_last))
        else $error("meshlet end did not clear the stream");

endmodule

// ===== hw/rtl/meshlet_position_bit_unpacker_core.sv =====
`timescale 1ns / 1ps
// An accepted word passes the word queue, the back-end sequencer, the extract register
// and the result queue before its first vertex reaches the result ports. The back end
// takes one word at a time, shifting out one vertex per cycle while the queue has room.
// A word with vertex_total zero is dropped at the input and costs nothing downstream.
// Reset (synchronous, active low) zeroes the control registers, bit buffer and queues.
module meshlet_position_bit_unpacker_core #(
    parameter int MID_DEPTH = mpbu_pkg::MID_DEPTH,
    parameter int OUT_DEPTH = mpbu_pkg::OUT_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [2:0]                           i_cfg_index,
    input  logic [mpbu_pkg::WORD_BITS-1:0]       i_cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic [mpbu_pkg::WORD_BITS-1:0]       i_stream_word,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [mpbu_pkg::WORD_BITS-1:0] o_pos_x,
    output logic signed [mpbu_pkg::WORD_BITS-1:0] o_pos_y,
    output logic signed [mpbu_pkg::WORD_BITS-1:0] o_pos_z,
    output logic [7:0]                           o_vertex_number,
    output logic                                 o_final_vertex
);
    localparam int MW = $bits(mpbu_pkg::t_mid_item);
    localparam int RW = $bits(mpbu_pkg::t_result);

    mpbu_pkg::t_cfg        cfg;
    mpbu_pkg::t_mid_item   mid_in;
    mpbu_pkg::t_mid_item   mid_out;
    mpbu_pkg::t_result     res_in;
    mpbu_pkg::t_result     res_out;
    logic                  mid_push;
    logic                  mid_full;
    logic                  mid_pop;
    logic                  mid_empty;
    logic [MW-1:0]         mid_data;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic                  out_push;
    logic                  out_full;
    logic [RW-1:0]         out_data;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    assign full = mid_full;

    mpbu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_word      (i_stream_word),
        .i_mid_full  (mid_full),
        .o_mid_push  (mid_push),
        .o_mid_item  (mid_in),
        .o_cfg       (cfg)
    );

    mpbu_queue #(
        .WIDTH (MW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_data),
        .o_count (mid_count)
    );

    assign mid_out = mpbu_pkg::t_mid_item'(mid_data);

    mpbu_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_mid_empty (mid_empty),
        .i_mid_item  (mid_out),
        .o_mid_pop   (mid_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (res_in)
    );

    mpbu_queue #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (res_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_data),
        .o_count (out_count)
    );

    assign res_out         = mpbu_pkg::t_result'(out_data);
    assign o_pos_x         = res_out.pos_x;
    assign o_pos_y         = res_out.pos_y;
    assign o_pos_z         = res_out.pos_z;
    assign o_vertex_number = res_out.vertex_number;
    assign o_final_vertex  = res_out.final_vertex;

    a_mid_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_full |-> (mid_count == $bits(mid_count)'(MID_DEPTH)))
        else $error("word queue level out of step with full");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_full |-> !out_push)
        else $error("result queue written while full");

    a_drop_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && cfg.vtotal == '0) |=> (mid_count == $past(mid_count) - $past(mid_pop)))
        else $error("word queued with no vertices configured");

endmodule
